FILE: rtl/dts_pkg.sv
// Shared types and constants for the DFS topological sort unit.
// No dependencies; imported by every module in rtl/.
package dts_pkg;

  localparam int MaxVertices = 16;
  localparam int VERTEX_W    = 4;   // vertex index width
  localparam int COUNT_W     = 5;   // holds 0..MaxVertices
  localparam int ADDR_W      = 3;   // APB byte address width

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MaxVertices);
  localparam logic [VERTEX_W-1:0] SP_LIMIT = VERTEX_W'(MaxVertices - 1);

  // Register indexes on the APB port.
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,        // clear search state for a new run
    OP_ROOT_SKIP,   // root already visited, advance
    OP_ROOT_ENTER,  // start a new tree at the current root
    OP_STEP,        // one edge check or one pop
    OP_EMIT,        // load next order entry into the output register
    OP_CYCLE        // load the cycle report into the output register
  } dts_op_t;

  typedef struct packed {
    logic    row_wr;
    dts_op_t op;
  } dts_cmd_t;

  typedef struct packed {
    logic count_zero;    // effective vertex count is zero
    logic root_done;     // all roots tried
    logic root_visited;  // current root already visited
    logic top_done;      // top frame has no neighbor left
    logic sp_empty;      // no saved parent frame
    logic hit_cycle;     // current edge closes a cycle
    logic emit_last;     // next emitted vertex is the last one
  } dts_status_t;

endpackage

FILE: rtl/dfs_topological_sort_unit.sv
// Top level of the DFS topological sort unit with cycle detection.
// Depends on dts_pkg, dts_ctrl and dts_datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transaction carries one adjacency
//    row (row_index, row_bits). The transaction with last_row set stores its
//    row and starts the sort unless vertex_count is zero.
//  - Output channel (out_valid/out_ready): the vertices in topological order,
//    last set on the final one; or a single transaction with has_cycle set.
//  - APB port: register 0 (byte address 0) is vertex_count, reset 16.
//    Write it only while the unit is idle.
// Search:
//  - The search checks one edge per cycle through a single adjacency read
//    port: the roots are tried in index order, each entered vertex checks
//    its row one edge at a time and then goes onto the finish list, and
//    once all roots are done the finish list is loaded into the output
//    register one result at a time, last finished first.
//  - in_ready is low from the start of a run until the final result has
//    been loaded into the output register.
// Stalls: while out_ready is low the output register holds its transaction
// and the emit sequencer waits; nothing is dropped.
// Reset: synchronous, clears control state and sets vertex_count to 16.
// Stored rows are kept across runs; no clearing pass is needed.
module dfs_topological_sort_unit
  import dts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input rows
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VERTEX_W-1:0] row_index,
  input  logic [15:0]         row_bits,
  input  logic                last_row,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] vertex,
  output logic                has_cycle,
  output logic                last,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [COUNT_W-1:0] vertex_count;
  logic               reg_sel;
  dts_cmd_t           cmd;
  dts_status_t        status;

  // One register; word index is paddr[2], byte offset ignored.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_VERTEX_COUNT) ? {27'b0, vertex_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= MAX_COUNT;
    end else if (psel && penable && pwrite && pready
                 && (reg_sel == REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  dts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_row  (last_row),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dts_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .vertex_count (vertex_count),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .status       (status),
    .vertex       (vertex),
    .has_cycle    (has_cycle),
    .last         (last)
  );

  // A run that starts must take the unit busy in the next cycle.
  a_run_busy : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_row && !status.count_zero) |=> !in_ready)
    else $error("input accepted during a run");

  // A cycle report is always a lone final transaction with vertex 0.
  a_cycle_form : assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_cycle) |-> (last && (vertex == '0)))
    else $error("malformed cycle report");

  // Results are only loaded once the search has finished.
  a_emit_idle_in : assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == OP_EMIT) || (cmd.op == OP_CYCLE)) |-> !in_ready)
    else $error("result loaded while idle");

endmodule

FILE: rtl/dts_datapath.sv
// Datapath of the DFS sort: adjacency store, frame stack, visit sets,
// finish list and output payload register. Depends on dts_pkg.
module dts_datapath
  import dts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dts_cmd_t            cmd,
  input  logic [COUNT_W-1:0]  vertex_count,
  input  logic [VERTEX_W-1:0] row_index,
  input  logic [15:0]         row_bits,
  output dts_status_t         status,
  output logic [VERTEX_W-1:0] vertex,
  output logic                has_cycle,
  output logic                last
);

  logic [MaxVertices-1:0] adjacency [MaxVertices];
  logic [VERTEX_W-1:0]    stack_v   [MaxVertices];
  logic [COUNT_W-1:0]     stack_i   [MaxVertices];
  logic [VERTEX_W-1:0]    finish    [MaxVertices];

  logic [MaxVertices-1:0] visited;
  logic [MaxVertices-1:0] on_path;
  logic [COUNT_W-1:0]     finish_count;
  logic [VERTEX_W-1:0]    sp;
  logic [COUNT_W-1:0]     root;
  logic [VERTEX_W-1:0]    cur_v;
  logic [COUNT_W-1:0]     cur_i;

  logic [COUNT_W-1:0]     n;
  logic [VERTEX_W-1:0]    idx;
  logic [VERTEX_W-1:0]    root_v;
  logic [VERTEX_W-1:0]    sp_prev;
  logic                   edge_bit;
  logic                   push;

  assign n        = (vertex_count > MAX_COUNT) ? MAX_COUNT : vertex_count;
  assign idx      = cur_i[VERTEX_W-1:0];
  assign root_v   = root[VERTEX_W-1:0];
  assign sp_prev  = sp - VERTEX_W'(1);
  assign edge_bit = adjacency[cur_v][idx];

  assign status.count_zero   = (n == '0);
  assign status.root_done    = (root >= n);
  assign status.root_visited = visited[root_v];
  assign status.top_done     = (cur_i >= n);
  assign status.sp_empty     = (sp == '0);
  assign status.hit_cycle    = !status.top_done && edge_bit && on_path[idx];
  assign status.emit_last    = (finish_count == COUNT_W'(1));

  assign push = !status.top_done && edge_bit && !on_path[idx] && !visited[idx]
                && (sp < SP_LIMIT);

  // Storage arrays, no reset.
  always_ff @(posedge clk) begin
    if (cmd.row_wr) begin
      adjacency[row_index] <= row_bits;
    end
    if (cmd.op == OP_STEP) begin
      if (status.top_done) begin
        finish[finish_count[VERTEX_W-1:0]] <= cur_v;
      end else if (push) begin
        stack_v[sp] <= cur_v;
        stack_i[sp] <= cur_i + COUNT_W'(1);
      end
    end
  end

  // Search control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      visited      <= '0;
      on_path      <= '0;
      finish_count <= '0;
      sp           <= '0;
      root         <= '0;
      cur_v        <= '0;
      cur_i        <= '0;
    end else begin
      case (cmd.op)
        OP_INIT: begin
          visited      <= '0;
          on_path      <= '0;
          finish_count <= '0;
          sp           <= '0;
          root         <= '0;
        end
        OP_ROOT_SKIP: begin
          root <= root + COUNT_W'(1);
        end
        OP_ROOT_ENTER: begin
          visited <= visited | (MaxVertices'(1) << root_v);
          on_path <= on_path | (MaxVertices'(1) << root_v);
          cur_v   <= root_v;
          cur_i   <= '0;
          sp      <= '0;
          root    <= root + COUNT_W'(1);
        end
        OP_STEP: begin
          if (status.top_done) begin
            on_path      <= on_path & ~(MaxVertices'(1) << cur_v);
            finish_count <= finish_count + COUNT_W'(1);
            if (!status.sp_empty) begin
              cur_v <= stack_v[sp_prev];
              cur_i <= stack_i[sp_prev];
              sp    <= sp_prev;
            end
          end else if (push) begin
            visited <= visited | (MaxVertices'(1) << idx);
            on_path <= on_path | (MaxVertices'(1) << idx);
            cur_v   <= idx;
            cur_i   <= '0;
            sp      <= sp + VERTEX_W'(1);
          end else begin
            cur_i <= cur_i + COUNT_W'(1);
          end
        end
        OP_EMIT: begin
          finish_count <= finish_count - COUNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      vertex    <= finish[finish_count[VERTEX_W-1:0] - VERTEX_W'(1)];
      has_cycle <= 1'b0;
      last      <= status.emit_last;
    end else if (cmd.op == OP_CYCLE) begin
      vertex    <= '0;
      has_cycle <= 1'b1;
      last      <= 1'b1;
    end
  end

endmodule

FILE: rtl/dts_ctrl.sv
// Controller FSM of the DFS sort: input handshake, search sequencing,
// output valid. Depends on dts_pkg.
module dts_ctrl
  import dts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        last_row,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dts_status_t status,
  output dts_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_STEP,
    S_EMIT,
    S_CYCLE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_load;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.row_wr = in_valid && in_ready;
    cmd.op     = OP_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && last_row && !status.count_zero) begin
          cmd.op     = OP_INIT;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (status.root_done) begin
          state_next = S_EMIT;
        end else if (status.root_visited) begin
          cmd.op = OP_ROOT_SKIP;
        end else begin
          cmd.op     = OP_ROOT_ENTER;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.op = OP_STEP;
        if (status.top_done && status.sp_empty) begin
          state_next = S_ROOT;
        end else if (status.hit_cycle) begin
          state_next = S_CYCLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.op = OP_EMIT;
          if (status.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CYCLE: begin
        if (out_free) begin
          cmd.op     = OP_CYCLE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_load = (cmd.op == OP_EMIT) || (cmd.op == OP_CYCLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
